FILE: sv/fwe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwe_pkg
// types and constants shared by the fog register word encoder modules
// ----------------------------------------------------------------------------
package fwe_pkg;

  // float unit operations
  typedef enum logic [1:0] {
    FOP_ADD,
    FOP_SUB,
    FOP_MUL,
    FOP_DIV
  } fpu_op_t;

  // datapath micro-operations, one float operation each
  typedef enum logic [3:0] {
    UOP_DFN,
    UOP_DSE,
    UOP_P1,
    UOP_P2,
    UOP_A,
    UOP_B,
    UOP_C,
    UOP_HALF,
    UOP_DBL,
    UOP_SCALE,
    UOP_BMUL
  } uop_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_DPRE,
    F_DIV,
    F_NORM,
    F_ROUND,
    F_DONE
  } fpu_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ISSUE,
    S_WAIT,
    S_LOOP1,
    S_LOOP2,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic       load;
    logic       set_default;
    logic       fpu_start;
    uop_t       uop;
    logic [2:0] word_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic planes_equal;
    logic fpu_done;
    logic m_gt_one;
    logic m_small;
  } dp_status_t;

  // word positions in the sequence
  localparam logic [2:0] WORD_A     = 3'd0;
  localparam logic [2:0] WORD_BMANT = 3'd1;
  localparam logic [2:0] WORD_BSHFT = 3'd2;
  localparam logic [2:0] WORD_C     = 3'd3;
  localparam logic [2:0] WORD_COLOR = 3'd4;

  // register address bytes
  localparam logic [31:0] BASE_A     = 32'hEE00_0000;
  localparam logic [31:0] BASE_BMANT = 32'hEF00_0000;
  localparam logic [31:0] BASE_BSHFT = 32'hF000_0000;
  localparam logic [31:0] BASE_C     = 32'hF100_0000;
  localparam logic [31:0] BASE_COLOR = 32'hF200_0000;

  // single precision constants
  localparam logic [31:0] FP_ZERO     = 32'h0000_0000;
  localparam logic [31:0] FP_HALF     = 32'h3F00_0000;
  localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
  localparam logic [31:0] FP_TWO      = 32'h4000_0000;
  localparam logic [31:0] FP_INF      = 32'h7F80_0000;
  localparam logic [31:0] FP_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] FP_NEG_2P31 = 32'hCF00_0000;
  localparam logic [31:0] FP_BM_SCALE = 32'h4B00_001E;  // 8388638.0
  localparam logic [31:0] FP_2P24     = 32'h4B80_0000;

  localparam logic [7:0] NORM_STEP_LIMIT = 8'd255;

  function automatic logic fp_is_nan(input logic [31:0] x);
    fp_is_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

endpackage
`default_nettype wire

FILE: sv/fwe_fpu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwe_fpu
// shared multi-cycle single precision add, subtract, multiply and divide,
// round to nearest even with subnormals
// ----------------------------------------------------------------------------
module fwe_fpu import fwe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  fpu_op_t     op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] result
);

  fpu_state_t state;
  logic [50:0] mw;              // bit 49 weighs 1.0, bit 50 is carry
  logic signed [10:0] ex;
  logic        rs;
  logic        zsign;
  logic [23:0] mant_a;
  logic [23:0] mant_b;
  logic signed [10:0] exp_a;
  logic signed [10:0] exp_b;
  logic [24:0] rem;
  logic [26:0] q;
  logic [4:0]  cnt;

  // operand unpack
  logic        sa, sb;
  logic [7:0]  xa, xb, ea, eb;
  logic [23:0] ma, mb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, px;

  always_comb begin
    sa     = a[31];
    sb     = b[31] ^ (op == FOP_SUB);
    xa     = a[30:23];
    xb     = b[30:23];
    ea     = (xa == 8'd0) ? 8'd1 : xa;
    eb     = (xb == 8'd0) ? 8'd1 : xb;
    ma     = {xa != 8'd0, a[22:0]};
    mb     = {xb != 8'd0, b[22:0]};
    nan_a  = fp_is_nan(a);
    nan_b  = fp_is_nan(b);
    inf_a  = (xa == 8'hFF) && (a[22:0] == 23'd0);
    inf_b  = (xb == 8'hFF) && (b[22:0] == 23'd0);
    zero_a = (a[30:0] == 31'd0);
    zero_b = (b[30:0] == 31'd0);
    px     = sa ^ sb;
  end

  // special operands
  logic        spec;
  logic [31:0] spec_val;

  always_comb begin
    spec     = 1'b0;
    spec_val = FP_QNAN;
    unique case (op)
      FOP_ADD, FOP_SUB: begin
        if (nan_a || nan_b || (inf_a && inf_b && (sa != sb))) begin
          spec = 1'b1;
        end else if (inf_a) begin
          spec     = 1'b1;
          spec_val = {sa, FP_INF[30:0]};
        end else if (inf_b) begin
          spec     = 1'b1;
          spec_val = {sb, FP_INF[30:0]};
        end
      end
      FOP_MUL: begin
        if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
          spec = 1'b1;
        end else if (inf_a || inf_b) begin
          spec     = 1'b1;
          spec_val = {px, FP_INF[30:0]};
        end else if (zero_a || zero_b) begin
          spec     = 1'b1;
          spec_val = {px, 31'd0};
        end
      end
      FOP_DIV: begin
        if (nan_a || nan_b || (inf_a && inf_b) || (zero_a && zero_b)) begin
          spec = 1'b1;
        end else if (inf_a || zero_b) begin
          spec     = 1'b1;
          spec_val = {px, FP_INF[30:0]};
        end else if (zero_a || inf_b) begin
          spec     = 1'b1;
          spec_val = {px, 31'd0};
        end
      end
      default: spec = 1'b1;
    endcase
  end

  // add alignment
  logic        a_big, s_big, s_sml;
  logic [23:0] m_big, m_sml;
  logic [7:0]  e_big, e_sml, dexp;
  logic [49:0] sml_full, sml_sh, sml_al;
  logic        lost;
  logic [50:0] sum;

  always_comb begin
    a_big    = (ea > eb) || ((ea == eb) && (ma >= mb));
    m_big    = a_big ? ma : mb;
    m_sml    = a_big ? mb : ma;
    e_big    = a_big ? ea : eb;
    e_sml    = a_big ? eb : ea;
    s_big    = a_big ? sa : sb;
    s_sml    = a_big ? sb : sa;
    dexp     = e_big - e_sml;
    sml_full = {m_sml, 26'd0};
    if (dexp >= 8'd50) begin
      sml_sh = 50'd0;
      lost   = |m_sml;
    end else begin
      sml_sh = sml_full >> dexp;
      lost   = |(sml_full & ~({50{1'b1}} << dexp));
    end
    sml_al = {sml_sh[49:1], sml_sh[0] | lost};
    if (s_big == s_sml) begin
      sum = {1'b0, m_big, 26'd0} + {1'b0, sml_al};
    end else begin
      sum = {1'b0, m_big, 26'd0} - {1'b0, sml_al};
    end
  end

  // multiply step, full 48-bit product
  logic [47:0] prod;

  always_comb begin
    prod = mant_a * mant_b;
  end

  // divide step
  logic        ge;
  logic [23:0] rdiff;
  logic [26:0] q_next;

  always_comb begin
    ge     = rem >= {1'b0, mant_b};
    rdiff  = ge ? 24'(rem - {1'b0, mant_b}) : rem[23:0];
    q_next = {q[25:0], ge};
  end

  // rounding
  logic [23:0] keep;
  logic        up;
  logic [24:0] rsum;
  logic signed [10:0] ex_r;
  logic [31:0] packed_val;

  always_comb begin
    keep = mw[49:26];
    up   = mw[25] && ((|mw[24:0]) || keep[0]);
    rsum = {1'b0, keep} + {24'd0, up};
    ex_r = ex + $signed({10'd0, rsum[24]});
    if (ex_r >= 11'sd255) begin
      packed_val = {rs, FP_INF[30:0]};
    end else if (rsum[24]) begin
      packed_val = {rs, ex_r[7:0], 23'd0};
    end else begin
      packed_val = {rs, rsum[23] ? ex[7:0] : 8'd0, rsum[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (start) begin
            if (spec) begin
              result <= spec_val;
              state  <= F_DONE;
            end else begin
              unique case (op)
                FOP_ADD, FOP_SUB: begin
                  mw    <= sum;
                  ex    <= $signed({3'd0, e_big});
                  rs    <= s_big;
                  zsign <= sa & sb;
                  state <= F_NORM;
                end
                FOP_MUL: begin
                  mant_a <= ma;
                  mant_b <= mb;
                  rs     <= px;
                  zsign  <= px;
                  ex     <= $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd127;
                  state  <= F_MUL;
                end
                default: begin
                  mant_a <= ma;
                  mant_b <= mb;
                  rs     <= px;
                  zsign  <= px;
                  exp_a  <= $signed({3'd0, ea});
                  exp_b  <= $signed({3'd0, eb});
                  state  <= F_DPRE;
                end
              endcase
            end
          end
        end
        F_MUL: begin
          mw    <= {prod, 3'd0};
          state <= F_NORM;
        end
        F_DPRE: begin
          if (!mant_a[23]) begin
            mant_a <= {mant_a[22:0], 1'b0};
            exp_a  <= exp_a - 11'sd1;
          end else if (!mant_b[23]) begin
            mant_b <= {mant_b[22:0], 1'b0};
            exp_b  <= exp_b - 11'sd1;
          end else begin
            rem   <= {1'b0, mant_a};
            q     <= 27'd0;
            cnt   <= 5'd26;
            ex    <= exp_a - exp_b + 11'sd127;
            state <= F_DIV;
          end
        end
        F_DIV: begin
          rem <= {rdiff, 1'b0};
          q   <= q_next;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            mw    <= {1'b0, q_next, 22'd0, rdiff != 24'd0};
            state <= F_NORM;
          end
        end
        F_NORM: begin
          if (mw == 51'd0) begin
            result <= {zsign, 31'd0};
            state  <= F_DONE;
          end else if (mw[50]) begin
            mw <= {1'b0, mw[50:2], mw[1] | mw[0]};
            ex <= ex + 11'sd1;
          end else if (ex < 11'sd1) begin
            if (ex < -11'sd52) begin
              mw <= {50'd0, 1'b1};
              ex <= 11'sd1;
            end else begin
              mw <= {1'b0, mw[50:2], mw[1] | mw[0]};
              ex <= ex + 11'sd1;
            end
          end else if (!mw[49] && (ex > 11'sd1)) begin
            mw <= {mw[49:0], 1'b0};
            ex <= ex - 11'sd1;
          end else begin
            state <= F_ROUND;
          end
        end
        F_ROUND: begin
          result <= packed_val;
          state  <= F_DONE;
        end
        F_DONE: state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  assign done = (state == F_DONE);

endmodule
`default_nettype wire

FILE: sv/fwe_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwe_datapath
// request registers, coefficient registers, float unit and word assembly
// ----------------------------------------------------------------------------
module fwe_datapath import fwe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_status_t  sts,
  input  logic [2:0]  fog_type,
  input  logic [31:0] start_depth,
  input  logic [31:0] end_depth,
  input  logic [31:0] near_plane,
  input  logic [31:0] far_plane,
  input  logic [7:0]  fog_red,
  input  logic [7:0]  fog_green,
  input  logic [7:0]  fog_blue,
  output logic [31:0] reg_word
);

  logic [2:0]  ftype;
  logic [31:0] sz, ez, nz, fz;
  logic [7:0]  red, green, blue;
  logic [31:0] dfn, dse, p1, p2, coef_a, coef_c, m, a_fin;
  logic [31:0] e;
  logic [23:0] bm;

  logic        fpu_start;
  fpu_op_t     fop;
  logic [31:0] opa, opb, fres;
  logic        fdone;

  function automatic logic feq(input logic [31:0] x, input logic [31:0] y);
    feq = !fp_is_nan(x) && !fp_is_nan(y) &&
          ((x == y) || ((x[30:0] == 31'd0) && (y[30:0] == 31'd0)));
  endfunction

  function automatic logic [23:0] to_u24(input logic [31:0] x);
    logic [7:0] sh;
    sh = 8'd150 - x[30:23];
    if (x[31] || fp_is_nan(x) || (x < FP_ONE)) begin
      to_u24 = 24'd0;
    end else if (x >= FP_2P24) begin
      to_u24 = 24'hFF_FFFF;
    end else begin
      to_u24 = {1'b1, x[22:0]} >> sh[4:0];
    end
  endfunction

  // 2^(e mod 32) as a signed 32-bit integer, then as a float
  logic [4:0]  sh5;
  logic [31:0] pow2f;
  always_comb begin
    sh5   = e[4:0];
    pow2f = (sh5 == 5'd31) ? FP_NEG_2P31 : {1'b0, 8'd127 + {3'd0, sh5}, 23'd0};
  end

  // operand select
  always_comb begin
    fpu_start = cmd.fpu_start;
    fop       = FOP_MUL;
    opa       = m;
    opb       = FP_ONE;
    unique case (cmd.uop)
      UOP_DFN:   begin fop = FOP_SUB; opa = fz;     opb = nz;          end
      UOP_DSE:   begin fop = FOP_SUB; opa = ez;     opb = sz;          end
      UOP_P1:    begin fop = FOP_MUL; opa = fz;     opb = nz;          end
      UOP_P2:    begin fop = FOP_MUL; opa = dfn;    opb = dse;         end
      UOP_A:     begin fop = FOP_DIV; opa = p1;     opb = p2;          end
      UOP_B:     begin fop = FOP_DIV; opa = fz;     opb = dfn;         end
      UOP_C:     begin fop = FOP_DIV; opa = sz;     opb = dse;         end
      UOP_HALF:  begin fop = FOP_MUL; opa = m;      opb = FP_HALF;     end
      UOP_DBL:   begin fop = FOP_MUL; opa = m;      opb = FP_TWO;      end
      UOP_SCALE: begin fop = FOP_DIV; opa = coef_a; opb = pow2f;       end
      UOP_BMUL:  begin fop = FOP_MUL; opa = FP_BM_SCALE; opb = m;      end
      default:   begin fop = FOP_MUL; opa = m;      opb = FP_ONE;      end
    endcase
  end

  fwe_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .start  (fpu_start),
    .op     (fop),
    .a      (opa),
    .b      (opb),
    .done   (fdone),
    .result (fres)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ftype <= fog_type;
      sz    <= start_depth;
      ez    <= end_depth;
      nz    <= near_plane;
      fz    <= far_plane;
      red   <= fog_red;
      green <= fog_green;
      blue  <= fog_blue;
      e     <= 32'd1;
    end
    if (cmd.set_default) begin
      coef_a <= FP_ZERO;
      m      <= FP_HALF;
      coef_c <= FP_ZERO;
    end
    if (fdone) begin
      unique case (cmd.uop)
        UOP_DFN:   dfn    <= fres;
        UOP_DSE:   dse    <= fres;
        UOP_P1:    p1     <= fres;
        UOP_P2:    p2     <= fres;
        UOP_A:     coef_a <= fres;
        UOP_B:     m      <= fres;
        UOP_C:     coef_c <= fres;
        UOP_HALF: begin
          m <= fres;
          e <= e + 32'd1;
        end
        UOP_DBL: begin
          m <= fres;
          e <= e - 32'd1;
        end
        UOP_SCALE: a_fin <= fres;
        UOP_BMUL:  bm    <= to_u24(fres);
        default:   a_fin <= a_fin;
      endcase
    end
  end

  // status toward the controller
  always_comb begin
    sts.planes_equal = feq(fz, nz) || feq(ez, sz);
    sts.fpu_done     = fdone;
    sts.m_gt_one     = !m[31] && (m > FP_ONE) && (m <= FP_INF);
    sts.m_small      = !m[31] && (m != FP_ZERO) && (m < FP_HALF);
  end

  // word assembly, nan coefficients take the canonical pattern
  logic [31:0] a_bits, c_bits;
  always_comb begin
    a_bits = fp_is_nan(a_fin) ? FP_QNAN : a_fin;
    c_bits = fp_is_nan(coef_c) ? FP_QNAN : coef_c;
    unique case (cmd.word_sel)
      WORD_A:     reg_word = BASE_A | {12'd0, a_bits[31:12]};
      WORD_BMANT: reg_word = BASE_BMANT | {8'd0, bm};
      WORD_BSHFT: reg_word = BASE_BSHFT | e;
      WORD_C:     reg_word = BASE_C | {8'd0, ftype, 1'b0, c_bits[31:12]};
      WORD_COLOR: reg_word = BASE_COLOR | {8'd0, red, green, blue};
      default:    reg_word = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/fwe_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwe_ctrl
// sequencer: float operation order, normalization loops and word output
// ----------------------------------------------------------------------------
module fwe_ctrl import fwe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  output logic       word_valid,
  input  logic       word_ready,
  output logic [2:0] word_index,
  output dp_cmd_t    cmd,
  input  dp_status_t sts
);

  ctrl_state_t state, state_next;
  uop_t        uop, uop_next;
  logic [7:0]  steps, steps_next;
  logic [2:0]  idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      uop   <= UOP_DFN;
      steps <= 8'd0;
      idx   <= WORD_A;
    end else begin
      state <= state_next;
      uop   <= uop_next;
      steps <= steps_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    uop_next     = uop;
    steps_next   = steps;
    idx_next     = idx;
    cmd          = '0;
    cmd.uop      = uop;
    cmd.word_sel = idx;
    req_ready    = 1'b0;
    word_valid   = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.planes_equal) begin
          cmd.set_default = 1'b1;
          steps_next      = 8'd0;
          state_next      = S_LOOP1;
        end else begin
          uop_next   = UOP_DFN;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.fpu_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (sts.fpu_done) begin
          state_next = S_ISSUE;
          unique case (uop)
            UOP_DFN: uop_next = UOP_DSE;
            UOP_DSE: uop_next = UOP_P1;
            UOP_P1:  uop_next = UOP_P2;
            UOP_P2:  uop_next = UOP_A;
            UOP_A:   uop_next = UOP_B;
            UOP_B:   uop_next = UOP_C;
            UOP_C: begin
              steps_next = 8'd0;
              state_next = S_LOOP1;
            end
            UOP_HALF: begin
              steps_next = steps + 8'd1;
              state_next = S_LOOP1;
            end
            UOP_DBL: begin
              steps_next = steps + 8'd1;
              state_next = S_LOOP2;
            end
            UOP_SCALE: uop_next = UOP_BMUL;
            UOP_BMUL: begin
              idx_next   = WORD_A;
              state_next = S_EMIT;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_LOOP1: begin
        if (sts.m_gt_one && (steps != NORM_STEP_LIMIT)) begin
          uop_next   = UOP_HALF;
          state_next = S_ISSUE;
        end else begin
          steps_next = 8'd0;
          state_next = S_LOOP2;
        end
      end
      S_LOOP2: begin
        state_next = S_ISSUE;
        if (sts.m_small && (steps != NORM_STEP_LIMIT)) begin
          uop_next = UOP_DBL;
        end else begin
          uop_next = UOP_SCALE;
        end
      end
      S_EMIT: begin
        word_valid = 1'b1;
        if (word_ready) begin
          if (idx == WORD_COLOR) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign word_index = idx;

endmodule
`default_nettype wire

FILE: sv/fog_register_word_encoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fog_register_word_encoder_core
// fog set-up request in, five register load words out
// ----------------------------------------------------------------------------
// One request (fog type, start/end depth, near/far plane as single precision
// bit patterns, RGB color) produces five 32-bit register words in order:
// scaled A coefficient, B mantissa, B shift, type with c coefficient, color;
// word_index counts 0 to 4 and last_word marks the fifth. The block takes one
// request at a time: req_ready is high only while idle, and the next request
// is taken the cycle after the fifth word transfer. Timing is set by one
// shared multi-cycle float unit: add and subtract align the operands and
// normalize one shift at a time, multiply forms the full product and then
// normalizes, divide normalizes its operands, forms the quotient one bit per
// step and normalizes the result; zero, infinite or nan operands skip
// straight to the result. The normal path runs two subtracts, two multiplies
// and three divides, then B is scaled into [0.5, 1] by repeated multiplies
// by one half or by two, at most 255 of each, then one divide of A by 2^e
// and one multiply for the B mantissa. When far equals near or end equals
// start the coefficient math is skipped.
// ----------------------------------------------------------------------------
module fog_register_word_encoder_core import fwe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [2:0]  fog_type,
  input  logic [31:0] start_depth,
  input  logic [31:0] end_depth,
  input  logic [31:0] near_plane,
  input  logic [31:0] far_plane,
  input  logic [7:0]  fog_red,
  input  logic [7:0]  fog_green,
  input  logic [7:0]  fog_blue,
  // word channel
  output logic        word_valid,
  input  logic        word_ready,
  output logic [31:0] reg_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  // sequencer: operation order, normalization loop counts, word pointer
  fwe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word_index (word_index),
    .cmd        (cmd),
    .sts        (sts)
  );

  // operand registers, float unit and word assembly
  fwe_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .fog_type    (fog_type),
    .start_depth (start_depth),
    .end_depth   (end_depth),
    .near_plane  (near_plane),
    .far_plane   (far_plane),
    .fog_red     (fog_red),
    .fog_green   (fog_green),
    .fog_blue    (fog_blue),
    .reg_word    (reg_word)
  );

  // the fifth word closes the sequence
  assign last_word = (word_index == WORD_COLOR);

`ifndef ASSERT_OFF
  // a request is never taken while words are still being offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> !word_valid)
    else $error("request transfer while words pending");

  // after a non-final word transfer the next word follows in order
  a_word_order: assert property (@(posedge clk) disable iff (rst)
    word_valid && word_ready && !last_word |=>
      word_valid && (word_index == 3'($past(word_index) + 3'd1)))
    else $error("word sequence out of order");

  // the final word transfer returns the block to accepting requests
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    word_valid && word_ready && last_word |=> req_ready)
    else $error("not idle after final word");

  // the float unit only reports completion while the sequencer waits
  a_fpu_done: assert property (@(posedge clk) disable iff (rst)
    sts.fpu_done |-> !req_ready && !word_valid)
    else $error("float unit done outside of a computation");
`endif

endmodule
`default_nettype wire

FILE: dv/fog_word_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fog_word_checker
// predicts the five register words of every fog set-up request and compares
// ----------------------------------------------------------------------------
// Watches both channels. Each request transfer is run through a bit-exact
// single precision model of the fog coefficient math, and the five words it
// yields are queued. Each word transfer is compared with the oldest one.
// ----------------------------------------------------------------------------
module fog_word_checker import fwe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic [2:0]  fog_type,
  input  logic [31:0] start_depth,
  input  logic [31:0] end_depth,
  input  logic [31:0] near_plane,
  input  logic [31:0] far_plane,
  input  logic [7:0]  fog_red,
  input  logic [7:0]  fog_green,
  input  logic [7:0]  fog_blue,
  input  logic        word_valid,
  input  logic        word_ready,
  input  logic [31:0] reg_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          fail_count,
  output int          words_pending
);

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } fog_word_t;

  fog_word_t expected_words[$];

  // single precision pattern to double, exact
  function automatic real sp_to_real(input logic [31:0] b);
    real r;
    if (b[30:23] == 8'hFF) begin
      if (b[22:0] != 23'd0) return $bitstoreal(64'h7FF8_0000_0000_0000);
      return $bitstoreal({b[31], 11'h7FF, 52'd0});
    end
    if (b[30:0] == 31'd0) return $bitstoreal({b[31], 63'd0});
    if (b[30:23] == 8'd0) begin
      r = b[22:0] * 2.0 ** (-149);
      return b[31] ? -r : r;
    end
    return $bitstoreal({b[31], 11'(b[30:23] - 127 + 1023), b[22:0], 29'd0});
  endfunction

  // double to single precision, round to nearest even, nan made canonical
  function automatic logic [31:0] real_to_sp(input real x);
    logic [63:0] d, mant, kept, rem, half;
    logic        sgn;
    int          ex, sh;
    d   = $realtobits(x);
    sgn = d[63];
    if (d[62:52] == 11'h7FF) begin
      if (d[51:0] != 52'd0) return FP_QNAN;
      return {sgn, 8'hFF, 23'd0};
    end
    if (d[62:52] == 11'd0) return {sgn, 31'd0};
    ex   = int'(d[62:52]) - 1023;
    mant = {11'd0, 1'b1, d[51:0]};
    sh   = (ex >= -126) ? 29 : 29 + (-126 - ex);
    if (sh > 60) return {sgn, 31'd0};
    kept = mant >> sh;
    rem  = mant & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    if (ex < -126) return {sgn, kept[30:0]};  // subnormal, may round up to min normal
    if (kept == (64'd1 << 24)) begin
      kept = kept >> 1;
      ex   = ex + 1;
    end
    if (ex > 127) return {sgn, 8'hFF, 23'd0};
    return {sgn, 8'(ex + 127), kept[22:0]};
  endfunction

  // one rounding after an exact-enough double operation
  function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
    return real_to_sp(sp_to_real(a) + sp_to_real(b));
  endfunction

  function automatic logic [31:0] sp_sub(input logic [31:0] a, input logic [31:0] b);
    return real_to_sp(sp_to_real(a) - sp_to_real(b));
  endfunction

  function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
    return real_to_sp(sp_to_real(a) * sp_to_real(b));
  endfunction

  // zero divisor gives signed infinity, or nan for 0/0 and nan/0
  function automatic logic [31:0] sp_div(input logic [31:0] n, input logic [31:0] d);
    if (d[30:0] == 31'd0) begin
      if (fp_is_nan(n) || n[30:0] == 31'd0) return FP_QNAN;
      return {n[31] ^ d[31], 8'hFF, 23'd0};
    end
    return real_to_sp(sp_to_real(n) / sp_to_real(d));
  endfunction

  function automatic logic sp_equal(input logic [31:0] a, input logic [31:0] b);
    if (fp_is_nan(a) || fp_is_nan(b)) return 1'b0;
    return (a == b) || (a[30:0] == 31'd0 && b[30:0] == 31'd0);
  endfunction

  task automatic queue_fog_words(input logic [2:0] ftype, input logic [31:0] sz,
                                 input logic [31:0] ez, input logic [31:0] nz,
                                 input logic [31:0] fz, input logic [7:0] r,
                                 input logic [7:0] g, input logic [7:0] b);
    logic [31:0] coef_a, coef_b, coef_c, dfn, dse, mant, scaled_a, divisor, prod;
    logic [31:0] shift, bmant, w [5];
    logic [4:0]  sh;
    int          steps;
    if (sp_equal(fz, nz) || sp_equal(ez, sz)) begin
      coef_a = FP_ZERO;
      coef_b = FP_HALF;
      coef_c = FP_ZERO;
    end else begin
      dfn    = sp_sub(fz, nz);
      dse    = sp_sub(ez, sz);
      coef_a = sp_div(sp_mul(fz, nz), sp_mul(dfn, dse));
      coef_b = sp_div(fz, dfn);
      coef_c = sp_div(sz, dse);
    end
    // normalize B into [0.5, 1], each loop capped at 255 steps
    mant  = coef_b;
    shift = 32'd1;
    steps = 0;
    while (!fp_is_nan(mant) && sp_to_real(mant) > 1.0 && steps < 255) begin
      mant  = sp_mul(mant, FP_HALF);
      shift = shift + 32'd1;
      steps++;
    end
    steps = 0;
    while (!fp_is_nan(mant) && sp_to_real(mant) > 0.0 && sp_to_real(mant) < 0.5 &&
           steps < 255) begin
      mant  = sp_mul(mant, FP_TWO);
      shift = shift - 32'd1;
      steps++;
    end
    // 2^shift as a signed 32-bit int, so 31 gives -2^31
    sh       = shift[4:0];
    divisor  = (sh == 5'd31) ? FP_NEG_2P31 : {1'b0, 8'(127 + sh), 23'd0};
    scaled_a = sp_div(coef_a, divisor);
    prod     = sp_mul(FP_BM_SCALE, mant);
    if (fp_is_nan(prod) || !(sp_to_real(prod) >= 1.0)) bmant = 32'd0;
    else if (sp_to_real(prod) >= 16777216.0) bmant = 32'h00FF_FFFF;
    else bmant = 32'($rtoi(sp_to_real(prod)));
    w[0] = BASE_A | (scaled_a >> 12);
    w[1] = BASE_BMANT | bmant;
    w[2] = BASE_BSHFT | shift;
    w[3] = BASE_C | (32'(ftype) << 21) | (coef_c >> 12);
    w[4] = BASE_COLOR | {8'd0, r, g, b};
    for (int k = 0; k < 5; k++) begin
      expected_words.push_back('{w[k], 3'(k), k == 4});
    end
  endtask

  always @(posedge clk) begin
    fog_word_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (req_valid && req_ready) begin
        queue_fog_words(fog_type, start_depth, end_depth, near_plane, far_plane,
                        fog_red, fog_green, fog_blue);
      end
      if (word_valid && word_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h index %0d last %b", $time, reg_word,
                   word_index, last_word);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (reg_word !== want.word || word_index !== want.index ||
              last_word !== want.last) begin
            $display("%0t: word mismatch expected %h/%0d/%b actual %h/%0d/%b", $time,
                     want.word, want.index, want.last, reg_word, word_index, last_word);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// fog register word encoder testbench
// ----------------------------------------------------------------------------
// Directed requests over the special depth patterns, then random requests
// with random gaps on the request side and random stalls on the word side.
// A long word-side hold-off fills the block; one pause drains it fully.
// ----------------------------------------------------------------------------
module tb import fwe_pkg::*;;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  logic [2:0]  fog_type;
  logic [31:0] start_depth, end_depth, near_plane, far_plane;
  logic [7:0]  fog_red, fog_green, fog_blue;
  logic        word_valid;
  logic        word_ready;
  logic [31:0] reg_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          fail_count;
  int          words_pending;

  // stimulus controls seen by the word-side process
  logic        hold_words = 1'b0;
  logic        calm = 1'b0;

  fog_register_word_encoder_core dut (.*);

  fog_word_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // random depth: mostly sensible magnitudes, sometimes any pattern or a corner
  function automatic logic [31:0] pick_depth();
    logic [31:0] corners [12] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
      32'hFF80_0000, 32'h7FC0_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h0080_0000,
      32'h3F80_0000, 32'hFFFF_FFFF, 32'h007F_FFFF, 32'hBF80_0000};
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return {1'b0, 8'($urandom_range(112, 146)), 23'($urandom)};
    if (sel < 85) return $urandom;
    return corners[$urandom_range(0, 11)];
  endfunction

  task automatic send_request(input logic [2:0] t, input logic [31:0] s,
                              input logic [31:0] e, input logic [31:0] n,
                              input logic [31:0] f, input logic [23:0] rgb);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid   <= 1'b1;
    fog_type    <= t;
    start_depth <= s;
    end_depth   <= e;
    near_plane  <= n;
    far_plane   <= f;
    {fog_red, fog_green, fog_blue} <= rgb;
    // ready is stable at the falling edge, transfer happens at the next rising
    forever begin
      @(negedge clk);
      if (req_ready) begin
        @(posedge clk);
        break;
      end
    end
  endtask

  task automatic send_random();
    logic [31:0] n, f, s, e;
    n = pick_depth();
    f = pick_depth();
    s = pick_depth();
    e = pick_depth();
    // well-formed ordering for most requests
    if ($urandom_range(0, 3) != 0) begin
      if (n[31] == f[31] && n > f) {n, f} = {f, n};
      if (s[31] == e[31] && s > e) {s, e} = {e, s};
    end
    // occasional equal pairs take the default path
    if ($urandom_range(0, 19) == 0) f = n;
    if ($urandom_range(0, 19) == 0) e = s;
    send_request(3'($urandom), s, e, n, f, 24'($urandom));
  endtask

  // word side: random stall before each transfer, one long hold-off on request
  initial begin
    int stall;
    bit held;
    held       = 1'b0;
    word_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_words && !held) begin
        held = 1'b1;
        word_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        word_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      word_ready <= 1'b1;
      forever begin
        @(negedge clk);
        if (word_valid) begin
          @(posedge clk);
          break;
        end
      end
    end
  end

  initial begin
    rst         = 1'b1;
    req_valid   = 1'b0;
    fog_type    = '0;
    start_depth = '0;
    end_depth   = '0;
    near_plane  = '0;
    far_plane   = '0;
    fog_red     = '0;
    fog_green   = '0;
    fog_blue    = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default path, typical, extremes, zero divisors, nan, infinities
    send_request(3'd0, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h4120_0000,
                 24'h000000);
    send_request(3'd1, 32'h3F80_0000, 32'h4120_0000, 32'h40A0_0000, 32'h40A0_0000,
                 24'hFFFFFF);
    send_request(3'd2, 32'h4120_0000, 32'h42C8_0000, 32'h3DCC_CCCD, 32'h447A_0000,
                 24'h123456);
    send_request(3'd3, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000,
                 24'hFF00FF);
    send_request(3'd4, 32'h0000_0001, 32'h0000_0002, 32'h0000_0001, 32'h0000_0003,
                 24'h00FF00);
    send_request(3'd5, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
                 24'hA5A5A5);
    send_request(3'd6, 32'h7FC0_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h7FC0_0000,
                 24'h5A5A5A);
    send_request(3'd7, 32'h7F80_0000, 32'hFF80_0000, 32'h0000_0000, 32'h7F80_0000,
                 24'h0F0F0F);
    send_request(3'd7, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
                 24'hF0F0F0);
    send_request(3'd2, 32'h0000_0001, 32'hBF80_0000, 32'hBF80_0000, 32'h0000_0001,
                 24'h010203);
    send_request(3'd1, 32'h2000_0000, 32'h2000_0001, 32'h2000_0000, 32'h2000_0001,
                 24'h808080);
    send_request(3'd3, 32'h3F80_0000, 32'h4000_0000, 32'h4F00_0000, 32'h4F00_0001,
                 24'h7F7F7F);
    send_request(3'd4, 32'hC000_0000, 32'h4000_0000, 32'h7F00_0000, 32'h7F00_0001,
                 24'hFEDCBA);
    send_request(3'd5, 32'h0080_0000, 32'h007F_FFFF, 32'h007F_FFFF, 32'h0080_0000,
                 24'h000001);
    send_request(3'd6, 32'h447A_0000, 32'h3F80_0000, 32'h4120_0000, 32'h3F80_0000,
                 24'h800000);

    // random, with calm stretches
    for (int i = 0; i < 240; i++) begin
      if (i % 60 == 0) calm = ~calm;
      if (i == 100) begin
        // word side holds off while requests keep coming
        hold_words = 1'b1;
      end
      if (i == 170) begin
        // request side waits until the block has drained
        req_valid <= 1'b0;
        @(posedge clk);
        wait (words_pending == 0);
        @(posedge clk);
      end
      send_random();
    end
    req_valid <= 1'b0;

    // let the pending count take in the last transfer before waiting on it
    @(posedge clk);
    wait (words_pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
